[design/increasing_subsequence_counter_macros.svh]
// assertion macros for the increasing subsequence counter
`ifndef INCREASING_SUBSEQUENCE_COUNTER_MACROS_SVH
`define INCREASING_SUBSEQUENCE_COUNTER_MACROS_SVH

`ifndef SYNTH
// condition must never hold while out of reset
`define ISC_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("isc assertion failed");
// antecedent implies consequent in the next cycle
`define ISC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("isc assertion failed");
`else
`define ISC_ASSERT_NEVER(label, clk, rstn, cond)
`define ISC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[design/isc_pkg.sv]
package isc_pkg;

    localparam int MAX_ITEMS   = 1024;
    localparam int MAX_LENGTH  = 100;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int LEN_W       = 7;
    localparam int COUNT_W     = 27;
    localparam int VALUE_W     = 32;
    localparam int ADDR_W      = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_W-1:0] MODULUS = 27'd123456789;
    localparam logic [ADDR_W-1:0] ADDR_SUBSEQ_LENGTH = 3'd0;
    localparam logic [LEN_W-1:0] LENGTH_RESET = 7'd1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } out_item_t;

    // transaction after classification by the front end
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      drop;
        logic [IDX_W-1:0]          pos;
        logic [LEN_W-1:0]          len;
    } work_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WALK,
        BK_DRAIN,
        BK_COMMIT
    } back_state_t;

    // modular add of two reduced operands
    function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        logic [COUNT_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, MODULUS};
        if (s >= {1'b0, MODULUS}) begin
            return d[COUNT_W-1:0];
        end
        return s[COUNT_W-1:0];
    endfunction

endpackage

[design/increasing_subsequence_counter.sv]
// channel   | direction | handshake          | payload
// s_        | in        | s_valid / s_ready  | s_data  (value, last)
// m_        | out       | m_valid / m_ready  | m_data  (count, overflow)
// apb       | in        | psel/penable/pready| subsequence_length at 0x0
//
// an element at position n > 0 passes through the back end in steps: a pop, one
// row read of the count memory per earlier element, a wait for the read data,
// and a commit; the first element of a sequence is only popped and committed;
// a dropped element is only popped; a two-entry queue decouples the front end
// reset is synchronous, active low, and needs no clearing pass
// the back end holds a new transaction while a result waits on m_ready
`include "increasing_subsequence_counter_macros.svh"

module increasing_subsequence_counter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  isc_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output isc_pkg::out_item_t         m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [isc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import isc_pkg::*;

    logic [LEN_W-1:0] length_reg;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    work_item_t       q_in;
    work_item_t       q_out;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SUBSEQ_LENGTH) ? {25'd0, length_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= LENGTH_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == ADDR_SUBSEQ_LENGTH) begin
            length_reg <= pwdata[LEN_W-1:0];
        end
    end

    isc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_length (length_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_in)
    );

    isc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .item_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .item_out (q_out),
        .empty    (q_empty)
    );

    isc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_item  (q_out),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // checks
    `ISC_ASSERT_NEVER(a_count_reduced, aclk, aresetn, m_valid && (m_data.count >= MODULUS))
    `ISC_ASSERT_NEVER(a_no_push_full, aclk, aresetn, q_push && q_full)
    `ISC_ASSERT_NEVER(a_no_pop_empty, aclk, aresetn, q_pop && q_empty)
    `ISC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule

[design/isc_front.sv]
module isc_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  isc_pkg::in_item_t        s_data,
    input  logic [isc_pkg::LEN_W-1:0] cfg_length,
    input  logic                     q_full,
    output logic                     q_push,
    output isc_pkg::work_item_t      q_item
);
    import isc_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             drop;

    // accept whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign drop    = (count_reg == CNT_W'(MAX_ITEMS));

    // classify the transaction
    always_comb begin
        q_item.value = s_data.value;
        q_item.last  = s_data.last;
        q_item.drop  = drop;
        q_item.pos   = count_reg[IDX_W-1:0];
        q_item.len   = cfg_length;
    end

    // fill count of the current sequence
    always_comb begin
        count_next = count_reg;
        if (q_push) begin
            if (s_data.last) begin
                count_next = '0;
            end else if (!drop) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

[design/isc_queue.sv]
module isc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  isc_pkg::work_item_t item_in,
    output logic                full,
    input  logic                pop,
    output isc_pkg::work_item_t item_out,
    output logic                empty
);
    import isc_pkg::*;

    work_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    fill_reg;

    assign full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign item_out = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

[design/isc_back.sv]
module isc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  isc_pkg::work_item_t q_item,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output isc_pkg::out_item_t  m_data
);
    import isc_pkg::*;

    typedef logic [MAX_LENGTH-1:0][COUNT_W-1:0] row_t;

    // element store and per-length count rows
    logic signed [VALUE_W-1:0] value_mem [MAX_ITEMS];
    row_t                      row_mem [MAX_ITEMS];
    logic signed [VALUE_W-1:0] rd_value_reg;
    row_t                      rd_row_reg;

    back_state_t        state_reg;
    back_state_t        state_next;
    work_item_t         cur_reg;
    logic [IDX_W-1:0]   j_reg;
    logic               rd_pend_reg;
    logic [COUNT_W-1:0] acc_reg [MAX_LENGTH-1];
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;
    logic               dropped_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               out_busy;
    logic               rd_issue;
    logic               commit;
    logic               take;
    row_t               new_row;
    logic [COUNT_W-1:0] add_val;

    assign out_busy = out_valid_reg && !m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty && !out_busy) begin
                    if (q_item.drop) begin
                        state_next = BK_IDLE;
                    end else if (q_item.pos == '0) begin
                        state_next = BK_COMMIT;
                    end else begin
                        state_next = BK_WALK;
                    end
                end
            end
            BK_WALK: begin
                if (j_reg == cur_reg.pos - IDX_W'(1)) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:  state_next = BK_COMMIT;
            BK_COMMIT: state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        q_pop    = 1'b0;
        rd_issue = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            BK_IDLE:   q_pop = !q_empty && !out_busy;
            BK_WALK:   rd_issue = 1'b1;
            BK_DRAIN:  rd_issue = 1'b0;
            BK_COMMIT: commit = 1'b1;
            default:   q_pop = 1'b0;
        endcase
    end

    // earlier element counts only when strictly smaller
    assign take = rd_pend_reg && (rd_value_reg < cur_reg.value);

    // row for the new element and its contribution to the total
    always_comb begin
        new_row[0] = COUNT_W'(1);
        for (int k = 0; k < MAX_LENGTH - 1; k++) begin
            new_row[k+1] = acc_reg[k];
        end
        add_val = '0;
        if (cur_reg.len == LEN_W'(1)) begin
            add_val = COUNT_W'(1);
        end
        for (int k = 0; k < MAX_LENGTH - 1; k++) begin
            if (cur_reg.len == LEN_W'(k + 2)) begin
                add_val = acc_reg[k];
            end
        end
        total_next = mod_add(total_reg, add_val);
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            rd_value_reg <= value_mem[j_reg];
            rd_row_reg   <= row_mem[j_reg];
        end
        if (commit) begin
            value_mem[cur_reg.pos] <= cur_reg.value;
            row_mem[cur_reg.pos]   <= new_row;
        end
    end

    // walk datapath
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_item;
            j_reg   <= '0;
        end else if (rd_issue) begin
            j_reg <= j_reg + IDX_W'(1);
        end
        for (int k = 0; k < MAX_LENGTH - 1; k++) begin
            if (q_pop) begin
                acc_reg[k] <= '0;
            end else if (take) begin
                acc_reg[k] <= mod_add(acc_reg[k], rd_row_reg[k]);
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (q_pop && q_item.drop) begin
            out_data_reg.count    <= total_reg;
            out_data_reg.overflow <= 1'b1;
        end else if (commit) begin
            out_data_reg.count    <= total_next;
            out_data_reg.overflow <= dropped_reg;
        end
    end

    // control state, running total and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            rd_pend_reg   <= 1'b0;
            total_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_issue;
            // result valid: set when a sequence ends, cleared on acceptance
            if ((q_pop && q_item.drop && q_item.last) || (commit && cur_reg.last)) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop && q_item.drop) begin
                if (q_item.last) begin
                    total_reg   <= '0;
                    dropped_reg <= 1'b0;
                end else begin
                    dropped_reg <= 1'b1;
                end
            end else if (commit) begin
                if (cur_reg.last) begin
                    total_reg   <= '0;
                    dropped_reg <= 1'b0;
                end else begin
                    total_reg <= total_next;
                end
            end
        end
    end

endmodule
